FILE: rtl/core/coordinate_seeded_height_displacement_top_defines.svh
// Assertion macros used by the height displacement RTL.
`ifndef COORDINATE_SEEDED_HEIGHT_DISPLACEMENT_TOP_DEFINES_SVH
`define COORDINATE_SEEDED_HEIGHT_DISPLACEMENT_TOP_DEFINES_SVH

`ifndef NO_ASSERTIONS
// Check a property on clk, quiet while arst_n is low.
`define CSH_ASSERT(label, prop) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error("csh assertion failed");
// Check that a condition never holds.
`define CSH_ASSERT_NEVER(label, cond) \
	`CSH_ASSERT(label, !(cond))
`else
`define CSH_ASSERT(label, prop)
`define CSH_ASSERT_NEVER(label, cond)
`endif

`endif

FILE: rtl/core/csh_pkg.sv
`timescale 1ns / 1ps
package csh_pkg;

	localparam logic [15:0] LCG_MUL      = 16'h7ABD;
	localparam logic [15:0] LCG_ADD      = 16'h1B0F;
	localparam logic [15:0] POLE_Y       = 16'h03C0;
	localparam logic [15:0] POLE_MIRROR  = 16'h0781;
	localparam logic [15:0] POLE_SHIFT_X = 16'h0480;
	localparam logic [15:0] ANCHOR_RANGE = 16'hFFFE;
	localparam logic [15:0] ANCHOR_LOW   = 16'h0001;
	localparam logic signed [15:0] HEIGHT_MAX = 16'sd127;
	localparam logic signed [15:0] HEIGHT_MIN = -16'sd127;

	localparam int CFG_IDX_W = 4;
	localparam logic [CFG_IDX_W-1:0] CFG_ANCHOR_ENABLE = 4'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_X_ORIGIN      = 4'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_Y_ORIGIN      = 4'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_GLOBAL_SEED   = 4'd3;

	typedef enum logic [3:0] {
		S_IDLE,
		S_Y_LCG,
		S_Y_DRAW,
		S_X_LCG,
		S_X_DRAW,
		S_MIX,
		S_LCG,
		S_DRAW,
		S_SUM
	} state_t;

	typedef enum logic [3:0] {
		STEP_NONE,
		STEP_Y_LCG,
		STEP_Y_DRAW,
		STEP_X_LCG,
		STEP_X_DRAW,
		STEP_MIX,
		STEP_LCG,
		STEP_DRAW,
		STEP_SUM
	} step_t;

	typedef struct packed {
		logic  load;
		step_t step;
		logic  out_load;
	} cmd_t;

	typedef struct packed {
		logic anchor;
	} status_t;

endpackage

FILE: rtl/core/csh_ctrl.sv
`timescale 1ns / 1ps
`include "coordinate_seeded_height_displacement_top_defines.svh"
module csh_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	output logic             out_valid,
	input  logic             out_ready,
	input  csh_pkg::status_t status,
	output csh_pkg::cmd_t    cmd
);
	import csh_pkg::*;

	state_t state_q;
	state_t state_next;
	logic   out_valid_q;
	logic   accept;
	logic   out_free;

	assign accept   = in_valid && in_ready;
	assign out_free = !out_valid_q || out_ready;

	// Advance the sequence over the shared multiplier
	always_comb begin
		state_next = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					state_next = status.anchor ? S_Y_LCG : S_LCG;
				end
			end
			S_Y_LCG:  state_next = S_Y_DRAW;
			S_Y_DRAW: state_next = S_X_LCG;
			S_X_LCG:  state_next = S_X_DRAW;
			S_X_DRAW: state_next = S_MIX;
			S_MIX:    state_next = S_LCG;
			S_LCG:    state_next = S_DRAW;
			S_DRAW:   state_next = S_SUM;
			S_SUM: begin
				if (out_free) begin
					state_next = S_IDLE;
				end
			end
			default:  state_next = S_IDLE;
		endcase
	end

	// Drive datapath commands
	always_comb begin
		in_ready     = (state_q == S_IDLE);
		cmd.load     = accept;
		cmd.out_load = 1'b0;
		cmd.step     = STEP_NONE;
		unique case (state_q)
			S_IDLE:   cmd.step = STEP_NONE;
			S_Y_LCG:  cmd.step = STEP_Y_LCG;
			S_Y_DRAW: cmd.step = STEP_Y_DRAW;
			S_X_LCG:  cmd.step = STEP_X_LCG;
			S_X_DRAW: cmd.step = STEP_X_DRAW;
			S_MIX:    cmd.step = STEP_MIX;
			S_LCG:    cmd.step = STEP_LCG;
			S_DRAW:   cmd.step = STEP_DRAW;
			S_SUM: begin
				cmd.step     = STEP_SUM;
				cmd.out_load = out_free;
			end
			default:  cmd.step = STEP_NONE;
		endcase
	end

	// Hold state and result valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_next;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

	`CSH_ASSERT(a_anchor_start, accept && status.anchor |=> state_q == S_Y_LCG)
	`CSH_ASSERT(a_idle_holds, state_q == S_IDLE && !accept |=> state_q == S_IDLE)
	`CSH_ASSERT_NEVER(a_no_overwrite, cmd.out_load && out_valid_q && !out_ready)
	`CSH_ASSERT(a_sum_delivers,
		state_q == S_SUM && out_free |=> out_valid_q && state_q == S_IDLE)

endmodule

FILE: rtl/core/csh_dp.sv
`timescale 1ns / 1ps
module csh_dp (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [csh_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [15:0]                        cfg_data,
	input  logic signed [7:0]                  base_height,
	input  logic [15:0]                        cell_x,
	input  logic [15:0]                        cell_y,
	input  logic [14:0]                        spread,
	input  csh_pkg::cmd_t                      cmd,
	output csh_pkg::status_t                   status,
	output logic signed [7:0]                  height
);
	import csh_pkg::*;

	logic              anchor_enable_q;
	logic [15:0]       x_origin_q;
	logic [15:0]       y_origin_q;
	logic [15:0]       global_seed_q;
	logic [15:0]       seed_q;
	logic [15:0]       x_q;
	logic [15:0]       y_q;
	logic signed [7:0] base_q;
	logic [14:0]       spread_q;
	logic [15:0]       r1_q;
	logic [31:0]       prod_q;
	logic signed [7:0] height_q;

	logic [15:0]        x_sum;
	logic [15:0]        y_sum;
	logic [15:0]        x_fold;
	logic [15:0]        y_fold;
	logic [15:0]        lcg_next;
	logic [15:0]        draw_hi;
	logic [15:0]        mul_a;
	logic [15:0]        mul_b;
	logic               mul_en;
	logic [15:0]        disp;
	logic signed [15:0] sum;
	logic signed [7:0]  clamped;

	assign cfg_ready     = 1'b1;
	assign status.anchor = anchor_enable_q;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			anchor_enable_q <= 1'b0;
			x_origin_q      <= '0;
			y_origin_q      <= '0;
			global_seed_q   <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_ANCHOR_ENABLE: anchor_enable_q <= cfg_data[0];
				CFG_X_ORIGIN:      x_origin_q      <= cfg_data;
				CFG_Y_ORIGIN:      y_origin_q      <= cfg_data;
				CFG_GLOBAL_SEED:   global_seed_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	// Offset the coordinates and fold y over the poles
	always_comb begin
		x_sum  = cell_x + x_origin_q;
		y_sum  = cell_y + y_origin_q;
		x_fold = x_sum;
		y_fold = y_sum;
		if (y_sum[15]) begin
			y_fold = ~y_sum;
			x_fold = x_sum + POLE_SHIFT_X;
		end else if (y_sum >= POLE_Y) begin
			y_fold = POLE_MIRROR - y_sum;
			x_fold = x_sum + POLE_SHIFT_X;
		end
	end

	// Finish the pending LCG step and read the draw's high half
	assign lcg_next = prod_q[15:0] + LCG_ADD;
	assign draw_hi  = prod_q[31:16];

	// Select multiplier operands
	always_comb begin
		mul_a  = seed_q;
		mul_b  = LCG_MUL;
		mul_en = 1'b0;
		unique case (cmd.step) inside
			STEP_Y_LCG: begin
				mul_a  = y_q;
				mul_en = 1'b1;
			end
			STEP_Y_DRAW, STEP_X_DRAW: begin
				mul_a  = lcg_next;
				mul_b  = ANCHOR_RANGE;
				mul_en = 1'b1;
			end
			STEP_X_LCG: begin
				mul_a  = x_q;
				mul_en = 1'b1;
			end
			STEP_LCG: begin
				mul_en = 1'b1;
			end
			STEP_DRAW: begin
				mul_a  = lcg_next;
				mul_b  = {spread_q, 1'b0};
				mul_en = 1'b1;
			end
			default: ;
		endcase
	end

	// Capture the item, run the multiplier, update the seed
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			x_q      <= x_fold;
			y_q      <= y_fold;
			base_q   <= base_height;
			spread_q <= spread;
		end
		if (mul_en) begin
			prod_q <= mul_a * mul_b;
		end
		if (cmd.step == STEP_X_LCG) begin
			r1_q <= draw_hi + ANCHOR_LOW;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_q <= '0;
		end else if (cmd.step == STEP_MIX) begin
			seed_q <= (draw_hi + ANCHOR_LOW) ^ r1_q ^ global_seed_q;
		end else if (cmd.step == STEP_DRAW) begin
			seed_q <= lcg_next;
		end
	end

	// Add displacement to the base and clamp
	always_comb begin
		disp = draw_hi - {1'b0, spread_q};
		sum  = $signed(disp + {{8{base_q[7]}}, base_q});
		if (sum > HEIGHT_MAX) begin
			clamped = HEIGHT_MAX[7:0];
		end else if (sum < HEIGHT_MIN) begin
			clamped = HEIGHT_MIN[7:0];
		end else begin
			clamped = sum[7:0];
		end
	end

	// Hold the result until transfer
	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			height_q <= clamped;
		end
	end

	assign height = height_q;

endmodule

FILE: rtl/core/coordinate_seeded_height_displacement_top.sv
`timescale 1ns / 1ps
// Coordinate-seeded height displacement: each accepted item (base height, cell x/y,
// spread) yields one height = clamp(base + draw(-spread..spread-1), +/-127). With
// anchor_enable set the seed is rebuilt from the folded cell coordinates and the
// global seed, otherwise the running seed continues. One 16x16 multiplier is shared
// by every LCG step and draw, one product per cycle. An item runs the y and x anchor
// LCG steps, draws and seed mix if anchoring is on, then the LCG step, draw and sum;
// the next item is taken in the cycle after the result enters the output register,
// even if it has not been transferred. A result still waiting when the next item
// finishes holds that item in its last step until the transfer. The user must write
// configuration through cfg_valid/cfg_index/cfg_data while idle; nothing checks it.
module coordinate_seeded_height_displacement_top (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [csh_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [15:0]                   cfg_data,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic signed [7:0]             base_height,
	input  logic [15:0]                   cell_x,
	input  logic [15:0]                   cell_y,
	input  logic [14:0]                   spread,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic signed [7:0]             height
);
	import csh_pkg::*;

	cmd_t    cmd;
	status_t status;

	csh_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.status    (status),
		.cmd       (cmd)
	);

	csh_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.base_height (base_height),
		.cell_x      (cell_x),
		.cell_y      (cell_y),
		.spread      (spread),
		.cmd         (cmd),
		.status      (status),
		.height      (height)
	);

endmodule

FILE: test/testbench.sv
`timescale 1ns / 1ps
module testbench;
	import csh_pkg::*;

	localparam int WATCHDOG_LIMIT = 4000;
	localparam int PHASE_ITEMS    = 175;
	localparam int PHASE_COUNT    = 8;

	// Track seed and register copies, predict each height and hold the expected ones
	class height_tracker;
		bit                anchor_on;
		logic [15:0]       x_org;
		logic [15:0]       y_org;
		logic [15:0]       world_seed;
		logic [15:0]       seed;
		logic signed [7:0] expected_heights[$];
		int                errors;

		function new();
			anchor_on  = 1'b0;
			x_org      = '0;
			y_org      = '0;
			world_seed = '0;
			seed       = '0;
			errors     = 0;
		endfunction

		function int pending();
			return expected_heights.size();
		endfunction

		// Mirror a register write; unknown indexes leave everything alone
		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] data);
			case (idx)
				CFG_ANCHOR_ENABLE: anchor_on = data[0];
				CFG_X_ORIGIN:      x_org = data;
				CFG_Y_ORIGIN:      y_org = data;
				CFG_GLOBAL_SEED:   world_seed = data;
				default: ;
			endcase
		endfunction

		// Advance the seed one generator step and scale it into [low, low+range)
		function logic [15:0] lcg_draw(logic [15:0] low, logic [15:0] range);
			logic [31:0] prod;
			seed = seed * LCG_MUL + LCG_ADD;
			prod = {16'd0, seed} * {16'd0, range};
			return prod[31:16] + low;
		endfunction

		// Predict the height for one accepted cell and queue it
		function void note_cell(logic signed [7:0] base, logic [15:0] cx, logic [15:0] cy,
				logic [14:0] spr);
			logic [15:0]        x;
			logic [15:0]        y;
			logic [15:0]        r1;
			logic [15:0]        r2;
			logic [15:0]        disp;
			logic [15:0]        sum;
			logic signed [15:0] s;
			if (anchor_on) begin
				x = cx + x_org;
				y = cy + y_org;
				// fold y over the poles, shifting x half way round
				if (y[15]) begin
					y = ~y;
					x = x + POLE_SHIFT_X;
				end else if (y >= POLE_Y) begin
					y = POLE_MIRROR - y;
					x = x + POLE_SHIFT_X;
				end
				seed = y;
				r1 = lcg_draw(ANCHOR_LOW, ANCHOR_RANGE);
				seed = x;
				r2 = lcg_draw(ANCHOR_LOW, ANCHOR_RANGE);
				seed = r1 ^ r2 ^ world_seed;
			end
			disp = lcg_draw(16'd0 - {1'b0, spr}, {spr, 1'b0});
			sum = disp + {{8{base[7]}}, base};
			s = sum;
			if (s > HEIGHT_MAX)
				s = HEIGHT_MAX;
			else if (s < HEIGHT_MIN)
				s = HEIGHT_MIN;
			expected_heights.push_back(s[7:0]);
		endfunction

		// Compare one transferred height with the oldest prediction
		function void check_height(logic signed [7:0] actual);
			logic signed [7:0] exp_h;
			if (expected_heights.size() == 0) begin
				$error("height: no result expected, actual %0d", actual);
				errors++;
			end else begin
				exp_h = expected_heights.pop_front();
				if (actual !== exp_h) begin
					$error("height: expected %0d, actual %0d", exp_h, actual);
					errors++;
				end
			end
		endfunction
	endclass

	logic                  clk;
	logic                  arst_n = 1'b0;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [15:0]           cfg_data = '0;
	logic                  in_valid = 1'b0;
	logic                  in_ready;
	logic signed [7:0]     base_height = '0;
	logic [15:0]           cell_x = '0;
	logic [15:0]           cell_y = '0;
	logic [14:0]           spread = '0;
	logic                  out_valid;
	logic                  out_ready = 1'b0;
	logic signed [7:0]     height;

	height_tracker tracker = new();
	bit            steady = 1'b0;
	int            idle_cycles = 0;

	coordinate_seeded_height_displacement_top u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.base_height (base_height),
		.cell_x      (cell_x),
		.cell_y      (cell_y),
		.spread      (spread),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.height      (height)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Mostly short gaps, a few long ones, none during steady stretches
	function automatic int pick_gap();
		int r;
		if (steady)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 50)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(10, 50);
	endfunction

	// Check every transferred height
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			tracker.check_height(height);
	end

	// Abort when nothing transfers for too long
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("Test completed with failures");
				$finish;
			end
		end
	end

	// Toggle out_ready: runs of ready broken by random stalls
	initial begin
		int n;
		@(posedge arst_n);
		forever begin
			n = $urandom_range(1, 8);
			out_ready <= 1'b1;
			repeat (n) @(posedge clk);
			n = pick_gap();
			if (n > 0) begin
				out_ready <= 1'b0;
				repeat (n) @(posedge clk);
			end
		end
	end

	// Present one cell, wait for its transfer, then idle at random
	task automatic send_item(input logic signed [7:0] b, input logic [15:0] x,
			input logic [15:0] y, input logic [14:0] s);
		int gap;
		in_valid    <= 1'b1;
		base_height <= b;
		cell_x      <= x;
		cell_y      <= y;
		spread      <= s;
		do @(posedge clk); while (!in_ready);
		tracker.note_cell(b, x, y, s);
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Hold off input until every predicted height has been transferred
	task automatic drain();
		in_valid <= 1'b0;
		while (tracker.pending() != 0) @(posedge clk);
	endtask

	// Drain, then write an unknown index followed by all four registers
	task automatic write_config(input bit anchor, input logic [15:0] xo,
			input logic [15:0] yo, input logic [15:0] gs);
		logic [CFG_IDX_W-1:0] idx [5];
		logic [15:0]          data [5];
		logic [15:0]          junk;
		drain();
		junk    = 16'($urandom);
		idx[0]  = CFG_IDX_W'($urandom_range(CFG_GLOBAL_SEED + 1, (1 << CFG_IDX_W) - 1));
		data[0] = 16'($urandom);
		idx[1]  = CFG_ANCHOR_ENABLE;
		data[1] = {junk[15:1], anchor};
		idx[2]  = CFG_X_ORIGIN;
		data[2] = xo;
		idx[3]  = CFG_Y_ORIGIN;
		data[3] = yo;
		idx[4]  = CFG_GLOBAL_SEED;
		data[4] = gs;
		for (int i = 0; i < 5; i++) begin
			cfg_valid <= 1'b1;
			cfg_index <= idx[i];
			cfg_data  <= data[i];
			do @(posedge clk); while (!cfg_ready);
			tracker.write_reg(idx[i], data[i]);
		end
		cfg_valid <= 1'b0;
	endtask

	// Random cell, with y often steered near a pole boundary and spread mostly small
	task automatic send_random();
		logic signed [7:0] b;
		logic [15:0]       x;
		logic [15:0]       y;
		logic [15:0]       tgt;
		logic [14:0]       s;
		int                off;
		b = 8'($urandom);
		x = 16'($urandom);
		if ($urandom_range(0, 3) == 0) begin
			case ($urandom_range(0, 4))
				0: tgt = POLE_Y;
				1: tgt = POLE_MIRROR;
				2: tgt = 16'h8000;
				3: tgt = 16'h0000;
				default: tgt = 16'hFFFF;
			endcase
			off = $urandom_range(0, 6);
			y = tgt + off[15:0] - 16'd3 - tracker.y_org;
		end else begin
			y = 16'($urandom);
		end
		case ($urandom_range(0, 3)) inside
			0, 1: s = 15'($urandom_range(0, 255));
			2: s = 15'($urandom_range(0, 4095));
			default: s = 15'($urandom);
		endcase
		send_item(b, x, y, s);
	endtask

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// Running seed straight from reset
		send_item(8'sd0, 16'h0000, 16'h0000, 15'd0);
		send_item(8'sd127, 16'hFFFF, 16'hFFFF, 15'h7FFF);
		send_item(-8'sd128, 16'h1234, 16'h4321, 15'd1);

		// Anchored cells at the field extremes and around the poles
		write_config(1'b1, 16'h0000, 16'h0000, 16'h0000);
		send_item(8'sd127, 16'h0000, 16'h0000, 15'd0);
		send_item(-8'sd128, 16'hFFFF, 16'hFFFF, 15'h7FFF);
		send_item(8'sd0, 16'h0000, 16'h03BF, 15'd1);
		send_item(8'sd0, 16'h0000, 16'h03C0, 15'd1);
		send_item(8'sd5, 16'h1234, 16'h0781, 15'd100);
		send_item(-8'sd5, 16'h1234, 16'h7FFF, 15'd100);
		send_item(8'sd0, 16'h1234, 16'h8000, 15'd100);
		send_item(8'sd127, 16'hFFFF, 16'h0000, 15'h7FFF);
		send_item(-8'sd128, 16'h0000, 16'h0000, 15'h7FFF);
		send_item(-8'sd128, 16'h5555, 16'h02AA, 15'h4000);
		send_item(8'sd127, 16'hAAAA, 16'h0155, 15'h2AAA);

		// Origins and seed at their top values, then back to the running seed
		write_config(1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF);
		send_item(8'sd1, 16'h0001, 16'h0001, 15'd50);
		send_item(-8'sd1, 16'h0480, 16'h03C1, 15'd50);
		write_config(1'b0, 16'h0000, 16'h0000, 16'h0000);
		send_item(8'sd0, 16'h0000, 16'h0000, 15'd0);
		send_item(-8'sd128, 16'hFFFF, 16'hFFFF, 15'h7FFF);
		send_item(8'sd127, 16'h0000, 16'h0000, 15'd1);

		// Random phases, each under its own register setting
		for (int p = 0; p < PHASE_COUNT; p++) begin
			case (p) inside
				0: write_config(1'b1, 16'h0000, 16'h0000, 16'h0000);
				1: write_config(1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF);
				2, 5: write_config(1'b0, 16'($urandom), 16'($urandom), 16'($urandom));
				default: write_config(1'b1, 16'($urandom), 16'($urandom), 16'($urandom));
			endcase
			steady = (p == 1 || p == 6);
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				if (p == 3 && i == PHASE_ITEMS / 2)
					drain();
				send_random();
			end
		end
		steady = 1'b0;

		// Wait out the last results, then settle a little longer
		drain();
		repeat (20) @(posedge clk);
		if (tracker.pending() != 0) begin
			$error("height: %0d expected results never arrived", tracker.pending());
			tracker.errors++;
		end
		if (tracker.errors == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
